// ----- rtl/png_scanline_unfilter_macros.svh -----
// ---------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNGSU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNGSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pngsu_pkg.sv -----
// ---------------------------------------------------------------------------
// PNG scanline unfilter package
// Sizes, filter codes, register indexes and the predictor input bundle.
// ---------------------------------------------------------------------------
package pngsu_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int COL_W       = 12;
    localparam int CH_W        = 2;
    localparam int ADDR_W      = COL_W + CH_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;

    localparam int WIDTH_REG_W = 13;
    localparam int BPP_REG_W   = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = WIDTH_REG_W;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        filter_t    filter;
        logic [7:0] raw;
        logic [7:0] left;
        logic [7:0] up;
        logic [7:0] up_left;
    } recon_in_t;

endpackage

// ----- rtl/png_scanline_unfilter.sv -----
// ---------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds 8-bit PNG samples from the filtered byte stream, one byte a cycle while the output is not stalled.
// ---------------------------------------------------------------------------
//
//  channel   direction  signals                               contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser     filtered byte, image start
//  m_        out        m_tvalid m_tready m_tdata m_tlast     sample, channel, column, row end
//  cfg_      in         cfg_valid cfg_ready cfg_index cfg_data register writes
//
//  One byte enters per cycle unless a stalled sample blocks the input.
//  A sample waits in the rebuild stage after its acceptance: the prior-row
//  memory is read at acceptance; write-back and output load happen together.
//  Filter bytes give no output transaction.
//  Reset (aresetn low, synchronous) clears the counters and flags; the
//  prior-row memory is not cleared. A stall on m_tready holds the sample in
//  the rebuild stage and drops s_tready in the same cycle.
//
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pngsu_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] image_start

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] sample_value, [9:8] channel_index, [21:10] pixel_column, [23:22] zero
    output logic [pngsu_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast,   // row_done

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pngsu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pngsu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W  = pngsu_pkg::COL_W;
    localparam int CH_W   = pngsu_pkg::CH_W;
    localparam int ADDR_W = pngsu_pkg::ADDR_W;
    localparam int WR_W   = pngsu_pkg::WIDTH_REG_W;
    localparam int BP_W   = pngsu_pkg::BPP_REG_W;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [WR_W-1:0] image_width_reg;
    logic [BP_W-1:0] bytes_per_pixel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= WR_W'(1);
            bytes_per_pixel_reg <= BP_W'(pngsu_pkg::MAX_CHANNELS);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == pngsu_pkg::CFG_IMAGE_WIDTH) begin
                image_width_reg <= cfg_data;
            end
            if (cfg_index == pngsu_pkg::CFG_BYTES_PER_PIXEL) begin
                bytes_per_pixel_reg <= cfg_data[BP_W-1:0];
            end
        end
    end

    // Clamp the registers into their legal ranges.
    logic [WR_W-1:0] width_eff;
    logic [BP_W-1:0] bpp_eff;

    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = WR_W'(1);
        end else if (image_width_reg > WR_W'(pngsu_pkg::MAX_WIDTH)) begin
            width_eff = WR_W'(pngsu_pkg::MAX_WIDTH);
        end else begin
            width_eff = image_width_reg;
        end
        if (bytes_per_pixel_reg == '0) begin
            bpp_eff = BP_W'(1);
        end else if (bytes_per_pixel_reg > BP_W'(pngsu_pkg::MAX_CHANNELS)) begin
            bpp_eff = BP_W'(pngsu_pkg::MAX_CHANNELS);
        end else begin
            bpp_eff = bytes_per_pixel_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Row position state, advanced at input acceptance
    // -----------------------------------------------------------------------
    logic [COL_W-1:0]   column_count_reg, column_count_next;
    logic [CH_W-1:0]    channel_count_reg, channel_count_next;
    pngsu_pkg::filter_t filter_kind_reg, filter_kind_next;
    logic               awaiting_filter_reg, awaiting_filter_next;
    logic               on_first_row_reg, on_first_row_next;

    // Rebuild stage registers
    logic               s1_valid_reg;
    logic               s1_sample_reg;
    logic [7:0]         s1_raw_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_done_reg;
    logic               s1_first_reg;
    pngsu_pkg::filter_t s1_filter_reg;

    logic s_accept;
    logic is_filter_byte;
    logic out_free;
    logic s1_go;
    logic row_end;

    logic [BP_W-1:0] ch_inc;
    logic [WR_W-1:0] col_inc;

    assign out_free = !m_tvalid || m_tready;
    // A filter byte never waits; a sample waits for a free output register.
    assign s1_go    = !s1_sample_reg || out_free;
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    assign is_filter_byte = s_tuser || awaiting_filter_reg;
    assign ch_inc  = BP_W'(channel_count_reg) + BP_W'(1);
    assign col_inc = WR_W'(column_count_reg) + WR_W'(1);

    always_comb begin
        column_count_next    = column_count_reg;
        channel_count_next   = channel_count_reg;
        filter_kind_next     = filter_kind_reg;
        awaiting_filter_next = awaiting_filter_reg;
        on_first_row_next    = on_first_row_reg;
        row_end              = 1'b0;
        if (s_accept) begin
            if (is_filter_byte) begin
                // Open a new row; unknown codes fall back to no filter.
                if (s_tdata <= 8'(pngsu_pkg::FILT_PAETH)) begin
                    filter_kind_next = pngsu_pkg::filter_t'(s_tdata[2:0]);
                end else begin
                    filter_kind_next = pngsu_pkg::FILT_NONE;
                end
                column_count_next    = '0;
                channel_count_next   = '0;
                awaiting_filter_next = 1'b0;
                if (s_tuser) begin
                    on_first_row_next = 1'b1;
                end
            end else if (ch_inc >= bpp_eff) begin
                channel_count_next = '0;
                if (col_inc >= width_eff) begin
                    column_count_next    = '0;
                    row_end              = 1'b1;
                    awaiting_filter_next = 1'b1;
                    on_first_row_next    = 1'b0;
                end else begin
                    column_count_next = col_inc[COL_W-1:0];
                end
            end else begin
                channel_count_next = ch_inc[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg    <= '0;
            channel_count_reg   <= '0;
            filter_kind_reg     <= pngsu_pkg::FILT_NONE;
            awaiting_filter_reg <= 1'b1;
            on_first_row_reg    <= 1'b1;
            s1_valid_reg        <= 1'b0;
            s1_sample_reg       <= 1'b0;
        end else begin
            column_count_reg    <= column_count_next;
            channel_count_reg   <= channel_count_next;
            filter_kind_reg     <= filter_kind_next;
            awaiting_filter_reg <= awaiting_filter_next;
            on_first_row_reg    <= on_first_row_next;
            if (s_accept) begin
                s1_valid_reg  <= 1'b1;
                s1_sample_reg <= !is_filter_byte;
            end else if (s1_go) begin
                s1_valid_reg  <= 1'b0;
                s1_sample_reg <= 1'b0;
            end
        end
    end

    // Payload of the rebuild stage: capture the position before it advances.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_raw_reg    <= s_tdata;
            s1_ch_reg     <= channel_count_reg;
            s1_col_reg    <= column_count_reg;
            s1_done_reg   <= row_end;
            s1_first_reg  <= on_first_row_reg;
            s1_filter_reg <= filter_kind_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Prior-row store: read at acceptance, written back from the rebuild stage
    // -----------------------------------------------------------------------
    logic [7:0]        prior_mem [pngsu_pkg::STORE_DEPTH];
    logic [7:0]        prior_rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              wr_en;
    logic [7:0]        sample;

    assign rd_addr = {column_count_reg, channel_count_reg};
    assign wr_addr = {s1_col_reg, s1_ch_reg};
    assign rd_en   = s_accept && !is_filter_byte;
    assign wr_en   = s1_valid_reg && s1_sample_reg && out_free;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prior_mem[wr_addr] <= sample;
        end
        if (rd_en) begin
            prior_rdata_reg <= prior_mem[rd_addr];
        end
    end

    // -----------------------------------------------------------------------
    // Rebuild stage
    // -----------------------------------------------------------------------
    logic [31:0]          left_pixel_reg;
    logic [31:0]          up_left_pixel_reg;
    logic [7:0]           up_byte;
    pngsu_pkg::recon_in_t recon_in;

    // The first row has nothing above it.
    assign up_byte = s1_first_reg ? 8'd0 : prior_rdata_reg;

    always_comb begin
        recon_in.filter  = s1_filter_reg;
        recon_in.raw     = s1_raw_reg;
        recon_in.left    = left_pixel_reg[8*s1_ch_reg +: 8];
        recon_in.up      = up_byte;
        recon_in.up_left = up_left_pixel_reg[8*s1_ch_reg +: 8];
    end

    pngsu_recon u_recon (
        .in     (recon_in),
        .sample (sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_pixel_reg    <= '0;
            up_left_pixel_reg <= '0;
        end else if (s1_valid_reg && !s1_sample_reg) begin
            // Row start: the pixels left of column zero read as zero.
            left_pixel_reg    <= '0;
            up_left_pixel_reg <= '0;
        end else if (wr_en) begin
            left_pixel_reg[8*s1_ch_reg +: 8]    <= sample;
            up_left_pixel_reg[8*s1_ch_reg +: 8] <= up_byte;
        end
    end

    // -----------------------------------------------------------------------
    // Output register
    // -----------------------------------------------------------------------
    logic                              m_tvalid_reg;
    logic [pngsu_pkg::OUT_DATA_W-1:0]  m_tdata_reg;
    logic                              m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (wr_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            m_tdata_reg <= {2'b00, s1_col_reg, s1_ch_reg, sample};
            m_tlast_reg <= s1_done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // A stalled sample in the rebuild stage must block new input transactions.
    `PNGSU_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, s1_valid_reg && s1_sample_reg && !out_free, !s_tready, "input accepted while rebuild stage is stalled")
    // Write-back and a new read never meet on the same entry.
    `PNGSU_ASSERT_NOW(a_no_rw_collision, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr, "prior-row read and write hit the same entry")
    // Image start reopens the first row at column zero.
    `PNGSU_ASSERT_NEXT(a_image_start_resets, aclk, aresetn, s_accept && s_tuser, on_first_row_reg && !awaiting_filter_reg && column_count_reg == '0 && channel_count_reg == '0, "image start did not restart the first row")

endmodule

// ----- rtl/pngsu_recon.sv -----
// ---------------------------------------------------------------------------
// PNG sample reconstruction
// Applies one of the five row filters to a filtered byte.
// ---------------------------------------------------------------------------
module pngsu_recon (
    input  pngsu_pkg::recon_in_t in,
    output logic [7:0]           sample
);

    logic [8:0] sum_ab;
    logic [8:0] twice_c;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [8:0] pc;
    logic [7:0] paeth_pred;
    logic [7:0] pred;

    assign sum_ab  = {1'b0, in.left} + {1'b0, in.up};
    assign twice_c = {in.up_left, 1'b0};

    always_comb begin
        pa = (in.up >= in.up_left) ? in.up - in.up_left : in.up_left - in.up;
        pb = (in.left >= in.up_left) ? in.left - in.up_left : in.up_left - in.left;
        pc = (sum_ab >= twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
        if ((pa <= pb) && ({1'b0, pa} <= pc)) begin
            paeth_pred = in.left;
        end else if ({1'b0, pb} <= pc) begin
            paeth_pred = in.up;
        end else begin
            paeth_pred = in.up_left;
        end
    end

    always_comb begin
        case (in.filter)
            pngsu_pkg::FILT_SUB:   pred = in.left;
            pngsu_pkg::FILT_UP:    pred = in.up;
            pngsu_pkg::FILT_AVG:   pred = sum_ab[8:1];
            pngsu_pkg::FILT_PAETH: pred = paeth_pred;
            default:               pred = 8'd0;
        endcase
    end

    assign sample = in.raw + pred;

endmodule

// ----- tb/pngsu_sample_checker.sv -----
// ---------------------------------------------------------------------------
// PNG scanline unfilter sample checker
// Watches the byte, sample and register channels, rebuilds every sample from
// its own copy of the row state and compares each output transaction.
// ---------------------------------------------------------------------------
module pngsu_sample_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [pngsu_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] image_start

    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] sample_value, [9:8] channel_index, [21:10] pixel_column, [23:22] zero
    input  logic [pngsu_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,   // row_done

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pngsu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pngsu_pkg::CFG_DATA_W-1:0]    cfg_data,

    output int                                  error_count,
    output int                                  pending_results
);
    import pngsu_pkg::*;

    typedef struct {
        logic [7:0]       sample;
        logic [CH_W-1:0]  channel;
        logic [COL_W-1:0] column;
        logic             row_end;
    } sample_rec_t;

    sample_rec_t expected_samples [$];

    // predicted block state
    logic [7:0]             prior_row [STORE_DEPTH];
    logic [31:0]            left_px;
    logic [31:0]            up_left_px;
    int                     col_pos;
    int                     ch_pos;
    filter_t                row_filter;
    logic                   want_filter;
    logic                   top_row;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [BPP_REG_W-1:0]   bpp_reg;
    int                     results_seen;

    task automatic report_mismatch(input string msg);
        $display("pngsu_sample_checker: result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    // Advance the row state by one accepted byte; queue a sample if it makes one.
    task automatic rebuild_sample(input logic [7:0] byte_in, input logic start);
        int          w;
        int          p;
        int          ch;
        int          idx;
        int          a;
        int          b;
        int          c;
        int          v;
        int          pa;
        int          pb;
        int          pc;
        sample_rec_t rec;
        if (start || want_filter) begin
            if (start) top_row = 1'b1;
            row_filter  = (byte_in <= 8'd4) ? filter_t'(byte_in[2:0]) : FILT_NONE;
            col_pos     = 0;
            ch_pos      = 0;
            left_px     = '0;
            up_left_px  = '0;
            want_filter = 1'b0;
        end else begin
            w = (width_reg == 0) ? 1 : int'(width_reg);
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            p = (bpp_reg == 0) ? 1 : int'(bpp_reg);
            if (p > MAX_CHANNELS) p = MAX_CHANNELS;

            ch  = ch_pos & 3;
            idx = col_pos * MAX_CHANNELS + ch;
            if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;

            a = int'(left_px[ch*8 +: 8]);
            b = top_row ? 0 : int'(prior_row[idx]);
            c = int'(up_left_px[ch*8 +: 8]);

            case (row_filter)
                FILT_SUB:   v = byte_in + a;
                FILT_UP:    v = byte_in + b;
                FILT_AVG:   v = byte_in + ((a + b) >> 1);
                FILT_PAETH: begin
                    pa = (b > c) ? b - c : c - b;
                    pb = (a > c) ? a - c : c - a;
                    pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
                    if (pa <= pb && pa <= pc) v = byte_in + a;
                    else if (pb <= pc)        v = byte_in + b;
                    else                      v = byte_in + c;
                end
                default:    v = byte_in;
            endcase

            rec.sample  = v[7:0];
            rec.channel = ch[CH_W-1:0];
            rec.column  = col_pos[COL_W-1:0];
            rec.row_end = 1'b0;

            prior_row[idx]       = rec.sample;
            left_px[ch*8 +: 8]   = rec.sample;
            up_left_px[ch*8 +: 8] = b[7:0];

            // counters end the pixel or row once they reach or pass the limits
            ch_pos++;
            if (ch_pos >= p) begin
                ch_pos = 0;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos     = 0;
                    rec.row_end = 1'b1;
                    want_filter = 1'b1;
                    top_row     = 1'b0;
                end
            end
            expected_samples.push_back(rec);
        end
    endtask

    always @(posedge aclk) begin
        sample_rec_t want;
        if (!aresetn) begin
            expected_samples.delete();
            left_px     = '0;
            up_left_px  = '0;
            col_pos     = 0;
            ch_pos      = 0;
            row_filter  = FILT_NONE;
            want_filter = 1'b1;
            top_row     = 1'b1;
            width_reg   = WIDTH_REG_W'(1);
            bpp_reg     = BPP_REG_W'(4);
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_REG_W-1:0];
                else if (cfg_index == CFG_BYTES_PER_PIXEL)
                    bpp_reg = cfg_data[BPP_REG_W-1:0];
            end
            if (s_tvalid && s_tready)
                rebuild_sample(s_tdata[7:0], s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, tdata 0x%0h", m_tdata));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata[7:0] !== want.sample)
                        report_mismatch($sformatf("sample_value 0x%0h, expected 0x%0h",
                                                  m_tdata[7:0], want.sample));
                    if (m_tdata[9:8] !== want.channel)
                        report_mismatch($sformatf("channel_index %0d, expected %0d",
                                                  m_tdata[9:8], want.channel));
                    if (m_tdata[21:10] !== want.column)
                        report_mismatch($sformatf("pixel_column %0d, expected %0d",
                                                  m_tdata[21:10], want.column));
                    if (m_tlast !== want.row_end)
                        report_mismatch($sformatf("row_done %0b, expected %0b",
                                                  m_tlast, want.row_end));
                end
                results_seen++;
            end
        end
        pending_results = expected_samples.size();
    end

endmodule

// ----- tb/tb_png_scanline_unfilter.sv -----
// ---------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Feeds filtered PNG rows through the unfilter under random back-pressure and
// sender gaps, across several image geometries including out-of-range and
// widest settings; a side checker rebuilds and compares every sample.
// ---------------------------------------------------------------------------
module tb_png_scanline_unfilter;
    import pngsu_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 1650;  // input items over the whole run
    localparam int QUIET_ITEMS  = 250;   // final stretch without idling
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin

    logic                  aclk = 1'b0;
    logic                  aresetn;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // [7:0] data_byte
    logic                  s_tuser;     // [0] image_start

    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // [7:0] sample, [9:8] channel, [21:10] column
    logic                  m_tlast;     // row_done

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   error_count;
    int   pending_results;
    int   items_sent = 0;
    logic idle_on    = 1'b1;
    int   hold_asks  = 0;
    int   holds_done = 0;
    int   stall_cycles = 0;

    // Opening sequence, {image_start, data_byte}. Run it in the reset geometry
    // (one pixel of four channels per row).
    logic [8:0] directed_seq [0:22] = '{
        // no image start after reset: first row, Average on zero neighbors
        9'h003, 9'h0FF, 9'h000, 9'h080, 9'h07F,
        // Up from the row above
        9'h002, 9'h001, 9'h0FF, 9'h000, 9'h080,
        // Paeth broken off by an image start carrying an unknown code
        9'h004, 9'h0FF, 9'h0FF, 9'h1FF,
        // first row of the new image, acts as None
        9'h012, 9'h034, 9'h056, 9'h078,
        // Sub on the second row
        9'h001, 9'h000, 9'h0FF, 9'h080, 9'h001
    };

    always #5 aclk = ~aclk;

    png_scanline_unfilter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pngsu_sample_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // Offer one byte, starting from a falling edge; return at the falling edge
    // after its transaction. s_tvalid stays high for a following byte.
    task automatic send_byte(input logic [7:0] data_byte, input logic image_start);
        int gap;
        if (idle_on && (items_sent < RANDOM_ITEMS - QUIET_ITEMS)
                && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= image_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop valid, wait for every expected sample, then let the pipe run dry
    // (a filter byte may still be in flight).
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write both geometry registers back to back; hold cfg_valid between them.
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] width_val,
                                input logic [CFG_DATA_W-1:0] bpp_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= width_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= CFG_BYTES_PER_PIXEL;
        cfg_data  <= bpp_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One image of random rows; now and then break a row off early.
    task automatic send_image(input int rows, input int row_len);
        int         r;
        int         k;
        int         len;
        logic [7:0] code;
        for (r = 0; r < rows; r++) begin
            if ($urandom_range(0, 7) == 0)
                code = 8'($urandom_range(5, 255));
            else
                code = 8'($urandom_range(0, 4));
            send_byte(code, r == 0);
            len = row_len;
            if ($urandom_range(0, 11) == 0) len = $urandom_range(0, row_len - 1);
            for (k = 0; k < len; k++) send_byte(8'($urandom), 1'b0);
            if (len != row_len) break;
        end
    endtask

    initial begin : stimulus
        int ph;
        int target;
        int w_reg;
        int p_reg;
        int w_eff;
        int p_eff;
        int n;
        int k;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        drain_results();

        // Narrow the geometry in the middle of a row: the row ends at once.
        set_geometry(13'd4, 13'd3);
        send_byte(8'(FILT_NONE), 1'b1);
        repeat (12) send_byte(8'($urandom), 1'b0);
        send_byte(8'(FILT_PAETH), 1'b0);
        repeat (5) send_byte(8'($urandom), 1'b0);
        drain_results();
        set_geometry(13'd2, 13'd2);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'(FILT_AVG), 1'b0);
        repeat (4) send_byte(8'($urandom), 1'b0);
        drain_results();

        // Width above the maximum with zero channels: a long piece of a row.
        set_geometry(13'h1FFF, 13'd0);
        send_byte(8'(FILT_SUB), 1'b1);
        repeat (200) send_byte(8'($urandom), 1'b0);
        drain_results();

        // Exact maximum width with too many channels; a short piece of a row.
        set_geometry(CFG_DATA_W'(MAX_WIDTH), 13'd7);
        send_byte(8'(FILT_UP), 1'b1);
        repeat (30) send_byte(8'($urandom), 1'b0);
        drain_results();

        // Random phases: each starts an image after its register writes.
        ph = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (ph == 0) begin
                w_reg = 0;
                p_reg = 0;
            end else begin
                w_reg = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(0, 8);
                p_reg = $urandom_range(0, 7);
            end
            w_eff = (w_reg == 0) ? 1 : w_reg;
            p_eff = (p_reg == 0) ? 1 : ((p_reg > MAX_CHANNELS) ? MAX_CHANNELS : p_reg);
            idle_on = ($urandom_range(0, 3) != 0);
            set_geometry(CFG_DATA_W'(w_reg), CFG_DATA_W'(p_reg));
            // ask the receiver for a long hold-off while bytes keep coming
            if (ph == 1) hold_asks++;
            target = items_sent + $urandom_range(60, 160);
            if (target > RANDOM_ITEMS) target = RANDOM_ITEMS;
            send_image($urandom_range(1, 4), w_eff * p_eff);
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: loose bytes, rarely with an image start
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end else begin
                    send_image($urandom_range(1, 4), w_eff * p_eff);
                end
            end
            drain_results();
            ph++;
        end

        if (error_count == 0) begin
            $display("tb_png_scanline_unfilter: clean");
        end else begin
            $display("tb_png_scanline_unfilter: errors");
        end
        $finish;
    end

    // Receiver: random ready bursts, plus the requested long hold-off.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_on && (items_sent < RANDOM_ITEMS - QUIET_ITEMS)
                    && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 16);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_png_scanline_unfilter: errors");
            $finish;
        end
    end

endmodule
